@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off during reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Implication on the rising clock edge, switched off during reset.
`define ASSERT_IMP(label, clk, rst, pre, post) \
   `ASSERT_CLK(label, clk, rst, (pre) |-> (post))

`endif

@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, codes and sizes shared by the buddy page allocator and its checker.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int PAGE_W      = 12;
   localparam int PAGE_COUNT  = 4096;
   localparam int ORDER_COUNT = 10;
   localparam int ORDER_W     = 5;
   localparam int CSR_DATA_W  = 13;

   localparam logic [ORDER_W-1:0] NO_ORDER = 5'd31;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_INIT  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic CSR_FIRST_FREE = 1'b0;
   localparam logic CSR_END_PAGE   = 1'b1;

   localparam logic STAT_DONE     = 1'b0;
   localparam logic STAT_NO_BLOCK = 1'b1;

   typedef struct packed {
      logic [1:0]        action;
      logic [3:0]        req_order;
      logic [PAGE_W-1:0] page_index;
   } bpa_req_type;

   typedef struct packed {
      logic              status;
      logic [PAGE_W-1:0] block_page;
   } bpa_rsp_type;

   typedef struct packed {
      logic               used;
      logic [ORDER_W-1:0] order;
   } bpa_info_type;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_BUILD,
      S_PUSH_A,
      S_PUSH_B,
      S_SEARCH,
      S_UNLINK_RD,
      S_UNLINK_WR,
      S_SPLIT,
      S_MARK,
      S_FREE_RD,
      S_FREE_CHK,
      S_BUDDY_RD,
      S_BUDDY_CHK,
      S_RESP
   } bpa_state_type;

endpackage

@@ rtl/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a page array with per-order FIFO free lists.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Direction  Carries
//  request   req_valid/req_ready/req_data   in         action, order, page
//  response  rsp_valid/rsp_ready/rsp_data   out        status, block page
//  control   csr_we/csr_index/csr_wdata     in         first free, end page
//
// One sequencer drives a single adder/compare unit and three page memories
// (page state, next link, previous link), each with one write and one
// registered read. An init item sweeps the page state, then pushes every
// block that fits and steps down an order where none fits. An allocation
// searches the orders upward, unlinks the head block and splits it down; a
// free checks the page, then reads, unlinks and merges each free buddy.
// After reset the page state is swept before the first item is taken. The
// response sits in an output register, so a new item is taken while an
// earlier response still waits.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bpa_pkg::bpa_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bpa_pkg::bpa_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bpa_pkg::*;

   localparam int PW  = PAGE_W;
   localparam int OW  = $clog2(ORDER_COUNT + 1);
   localparam int KIW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
   localparam int CW  = ((ORDER_COUNT > 13) ? ORDER_COUNT : 13) + 2;
   localparam logic [OW-1:0] K_TOP = OW'(ORDER_COUNT - 1);
   localparam logic [OW-1:0] K_LIM = OW'(ORDER_COUNT);
   localparam logic [CW-1:0] ALIGN_MASK = (CW'(1) << ORDER_COUNT) - CW'(1);
   localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);

   // Control and payload registers.
   bpa_state_type   state_ff, state_in;
   logic [PW-1:0]   ffp_ff;
   logic [12:0]     endp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   bpa_rsp_type     rsp_ff, rsp_in;
   logic            status_ff, status_in;
   logic [PW-1:0]   page_ff, page_in;
   logic [1:0]      op_ff, op_in;
   logic [OW-1:0]   req_ff, req_in;
   logic            init_ff, init_in;
   logic [PW-1:0]   sweep_ff, sweep_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [PW-1:0]   p_ff, p_in;
   logic [PW-1:0]   u_ff, u_in;
   logic [OW-1:0]   k_ff, k_in;
   logic [PW-1:0]   head_ff [ORDER_COUNT];
   logic [PW-1:0]   head_in [ORDER_COUNT];
   logic [PW-1:0]   tail_ff [ORDER_COUNT];
   logic [PW-1:0]   tail_in [ORDER_COUNT];
   logic [PW:0]     cnt_ff  [ORDER_COUNT];
   logic [PW:0]     cnt_in  [ORDER_COUNT];

   // Page memories.
   bpa_info_type    info_mem [PAGE_COUNT];
   logic [PW-1:0]   next_mem [PAGE_COUNT];
   logic [PW-1:0]   prev_mem [PAGE_COUNT];
   bpa_info_type    info_rd_ff;
   logic [PW-1:0]   next_rd_ff, prev_rd_ff;

   logic            info_we, next_we, prev_we;
   logic [PW-1:0]   info_waddr, next_waddr, prev_waddr, info_raddr;
   bpa_info_type    info_wdata;
   logic [PW-1:0]   next_wdata, prev_wdata;

   // Shared arithmetic.
   logic [KIW-1:0]  k_idx;
   logic [PW-1:0]   head_k, tail_k;
   logic [PW:0]     cnt_k;
   logic            cnt_zero;
   logic [CW-1:0]   start_w, end_w, size_w, sum_w, bud_w;
   logic [PW-1:0]   pbit;
   logic            buddy_ok, is_head, is_tail, sw_free, sweep_last;
   logic            req_too_big, free_bad, buddy_match;

   assign k_idx    = k_ff[KIW-1:0];
   assign head_k   = head_ff[k_idx];
   assign tail_k   = tail_ff[k_idx];
   assign cnt_k    = cnt_ff[k_idx];
   assign cnt_zero = (cnt_k == '0);

   // The free region starts at the first free page rounded up to a multiple of
   // 2**ORDER_COUNT pages, and ends at the end page clamped to the page array.
   assign start_w = (CW'(ffp_ff) + ALIGN_MASK) & ~ALIGN_MASK;
   assign end_w   = (endp_ff > 13'(PAGE_COUNT)) ? CW'(PAGE_COUNT) : CW'(endp_ff);
   assign size_w  = CW'(1) << k_ff;
   assign sum_w   = i_ff + size_w;
   assign bud_w   = CW'(p_ff) ^ size_w;
   assign pbit    = size_w[PW-1:0];
   assign buddy_ok = (bud_w < CW'(PAGE_COUNT));
   assign is_head = (head_k == u_ff);
   assign is_tail = (tail_k == u_ff);
   assign sw_free = init_ff && (CW'(sweep_ff) >= start_w) && (CW'(sweep_ff) < end_w);
   assign sweep_last = (sweep_ff == LAST_PAGE);
   assign req_too_big = ({1'b0, req_data.req_order} >= 5'(ORDER_COUNT));
   assign free_bad = !info_rd_ff.used || (info_rd_ff.order >= 5'(ORDER_COUNT));
   assign buddy_match = !info_rd_ff.used && (info_rd_ff.order == ORDER_W'(k_ff));
   assign info_raddr = (state_ff == S_FREE_RD) ? p_ff : bud_w[PW-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state.
   always_comb begin
      bpa_state_type push_ret;
      push_ret = (op_ff == ACT_INIT) ? S_BUILD : ((op_ff == ACT_ALLOC) ? S_SPLIT : S_RESP);
      state_in = state_ff;
      unique case (state_ff)
         S_SWEEP: begin
            if (sweep_last) state_in = init_ff ? S_BUILD : S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.action)
                  ACT_ALLOC: state_in = req_too_big ? S_RESP : S_SEARCH;
                  ACT_FREE:  state_in = S_FREE_RD;
                  ACT_INIT:  state_in = S_SWEEP;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_BUILD: begin
            if (i_ff >= end_w) state_in = S_RESP;
            else if (sum_w <= end_w) state_in = S_PUSH_A;
         end
         S_PUSH_A:    state_in = cnt_zero ? push_ret : S_PUSH_B;
         S_PUSH_B:    state_in = push_ret;
         S_SEARCH: begin
            if (k_ff >= K_LIM) state_in = S_RESP;
            else if (!cnt_zero) state_in = S_UNLINK_RD;
         end
         S_UNLINK_RD: state_in = S_UNLINK_WR;
         S_UNLINK_WR: state_in = (op_ff == ACT_ALLOC) ? S_SPLIT : S_BUDDY_RD;
         S_SPLIT:     state_in = (k_ff > req_ff) ? S_PUSH_A : S_MARK;
         S_MARK:      state_in = S_RESP;
         S_FREE_RD:   state_in = S_FREE_CHK;
         S_FREE_CHK:  state_in = free_bad ? S_RESP : S_BUDDY_RD;
         S_BUDDY_RD:  state_in = (k_ff < K_TOP && buddy_ok) ? S_BUDDY_CHK : S_PUSH_A;
         S_BUDDY_CHK: state_in = buddy_match ? S_UNLINK_RD : S_PUSH_A;
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      status_in    = status_ff;
      page_in      = page_ff;
      op_in        = op_ff;
      req_in       = req_ff;
      init_in      = init_ff;
      sweep_in     = sweep_ff;
      i_in         = i_ff;
      p_in         = p_ff;
      u_in         = u_ff;
      k_in         = k_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      info_we      = 1'b0;
      info_waddr   = p_ff;
      info_wdata   = '{used: 1'b0, order: ORDER_W'(k_ff)};
      next_we      = 1'b0;
      next_waddr   = p_ff;
      next_wdata   = p_ff;
      prev_we      = 1'b0;
      prev_waddr   = p_ff;
      prev_wdata   = p_ff;
      unique case (state_ff)
         S_SWEEP: begin
            info_we    = 1'b1;
            info_waddr = sweep_ff;
            info_wdata = '{used: !sw_free, order: NO_ORDER};
            sweep_in   = sweep_ff + PW'(1);
            if (sweep_last) begin
               i_in = start_w;
               k_in = K_TOP;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.action;
               req_in    = OW'(req_data.req_order);
               k_in      = OW'(req_data.req_order);
               p_in      = req_data.page_index;
               page_in   = '0;
               status_in = (req_data.action == ACT_ALLOC && req_too_big) ?
                           STAT_NO_BLOCK : STAT_DONE;
               init_in   = 1'b0;
               if (req_data.action == ACT_INIT) begin
                  init_in  = 1'b1;
                  sweep_in = '0;
                  for (int j = 0; j < ORDER_COUNT; j++) cnt_in[j] = '0;
               end
            end
         end
         S_BUILD: begin
            if (i_ff < end_w) begin
               if (sum_w <= end_w) begin
                  p_in = i_ff[PW-1:0];
                  i_in = sum_w;
               end else begin
                  k_in = k_ff - OW'(1);
               end
            end
         end
         S_PUSH_A: begin
            // Block goes to the tail of its list and is marked free.
            info_we    = 1'b1;
            prev_we    = 1'b1;
            prev_wdata = cnt_zero ? p_ff : tail_k;
            next_we    = 1'b1;
            next_waddr = cnt_zero ? p_ff : tail_k;
            if (cnt_zero) head_in[k_idx] = p_ff;
            tail_in[k_idx] = p_ff;
            cnt_in[k_idx]  = cnt_k + 1'b1;
            if (cnt_zero && op_ff == ACT_ALLOC) p_in = p_ff + pbit;
         end
         S_PUSH_B: begin
            next_we = 1'b1;
            if (op_ff == ACT_ALLOC) p_in = p_ff + pbit;
         end
         S_SEARCH: begin
            if (k_ff >= K_LIM) begin
               status_in = STAT_NO_BLOCK;
            end else if (!cnt_zero) begin
               u_in = head_k;
               p_in = head_k;
            end else begin
               k_in = k_ff + OW'(1);
            end
         end
         S_UNLINK_WR: begin
            if (is_head && !is_tail) begin
               head_in[k_idx] = next_rd_ff;
            end else if (is_tail && !is_head) begin
               tail_in[k_idx] = prev_rd_ff;
               next_we    = 1'b1;
               next_waddr = prev_rd_ff;
               next_wdata = prev_rd_ff;
            end else if (!is_head && !is_tail) begin
               next_we    = 1'b1;
               next_waddr = prev_rd_ff;
               next_wdata = next_rd_ff;
               prev_we    = 1'b1;
               prev_waddr = next_rd_ff;
               prev_wdata = prev_rd_ff;
            end
            if (!cnt_zero) cnt_in[k_idx] = cnt_k - 1'b1;
            if (op_ff == ACT_FREE) begin
               // The upper half of the merged pair loses its order.
               info_we    = 1'b1;
               info_waddr = p_ff | pbit;
               info_wdata = '{used: 1'b0, order: NO_ORDER};
               p_in       = p_ff & ~pbit;
               k_in       = k_ff + OW'(1);
            end
         end
         S_SPLIT: begin
            if (k_ff > req_ff) k_in = k_ff - OW'(1);
         end
         S_MARK: begin
            info_we    = 1'b1;
            info_wdata = '{used: 1'b1, order: ORDER_W'(req_ff)};
            page_in    = p_ff;
         end
         S_FREE_CHK: begin
            if (!free_bad) k_in = OW'(info_rd_ff.order);
         end
         S_BUDDY_CHK: begin
            if (buddy_match) u_in = bud_w[PW-1:0];
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: status_ff, block_page: page_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ffp_ff       <= '0;
         endp_ff      <= 13'(PAGE_COUNT);
         for (int j = 0; j < ORDER_COUNT; j++) cnt_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIRST_FREE: ffp_ff  <= csr_wdata[PW-1:0];
               CSR_END_PAGE:   endp_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      page_ff   <= page_in;
      op_ff     <= op_in;
      req_ff    <= req_in;
      i_ff      <= i_in;
      p_ff      <= p_in;
      u_ff      <= u_in;
      k_ff      <= k_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
   end

   // Page memories, one write and one registered read each.
   always_ff @(posedge clock) begin
      if (info_we) info_mem[info_waddr] <= info_wdata;
      info_rd_ff <= info_mem[info_raddr];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      next_rd_ff <= next_mem[u_ff];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      prev_rd_ff <= prev_mem[u_ff];
   end

endmodule

@@ rtl/bpa_checker.sv @@
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the buddy page allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bpa_pkg::bpa_rsp_type rsp_data
);
   import bpa_pkg::*;

   // A stalled response item neither vanishes nor changes.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data))
   // A failed allocation never reports a page.
   `ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && rsp_data.status == STAT_NO_BLOCK, rsp_data.block_page == '0)
   // The block works on one item at a time.
   `ASSERT_CLK(a_busy, clock, reset, req_valid && req_ready |=> !req_ready)

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/buddy_page_allocator_test.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator_test
// Self-checking testbench for the buddy page allocator. A behavioural model of
// the free lists predicts the status and block page of every item; responses
// are compared in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module buddy_page_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int NPAGE = PAGE_COUNT;
   localparam int NORD  = ORDER_COUNT;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bpa_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bpa_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CSR_FIRST_FREE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   buddy_page_allocator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idling percentages for the sender and the receiver.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;

   // Model of the allocator state.
   logic [11:0] cfg_first_free;
   logic [12:0] cfg_end;
   bit          pg_used  [NPAGE];
   logic [4:0]  pg_order [NPAGE];
   int unsigned nxt [NPAGE];
   int unsigned prv [NPAGE];
   int unsigned head [NORD];
   int unsigned tail [NORD];
   int unsigned count [NORD];

   // Responses still owed by the allocator, oldest first.
   bpa_rsp_type owed_rsp [$];
   // Pages the stimulus currently holds as allocated, for well-formed frees.
   int unsigned held_pages [$];

   function automatic void push_free(int unsigned pg, int unsigned k);
      pg_used[pg] = 1'b0;
      pg_order[pg] = k[4:0];
      if (count[k] == 0) begin
         head[k] = pg;
         prv[pg] = pg;
      end else begin
         nxt[tail[k]] = pg;
         prv[pg] = tail[k];
      end
      nxt[pg] = pg;
      tail[k] = pg;
      count[k]++;
   endfunction

   function automatic void unlink_free(int unsigned pg, int unsigned k);
      bit at_head;
      bit at_tail;
      int unsigned nx;
      int unsigned pv;
      at_head = (head[k] == pg);
      at_tail = (tail[k] == pg);
      nx = nxt[pg] % NPAGE;
      pv = prv[pg] % NPAGE;
      if (at_head && at_tail) begin
      end else if (at_head) begin
         head[k] = nx;
      end else if (at_tail) begin
         tail[k] = pv;
         nxt[pv] = pv;
      end else begin
         nxt[pv] = nx;
         prv[nx] = pv;
      end
      if (count[k] > 0) count[k]--;
   endfunction

   function automatic void wipe_pages();
      for (int i = 0; i < NPAGE; i++) begin
         pg_used[i] = 1'b1;
         pg_order[i] = NO_ORDER;
      end
      for (int i = 0; i < NORD; i++) count[i] = 0;
   endfunction

   // Works out the response of one item and advances the model.
   function automatic bpa_rsp_type predict_alloc(bpa_req_type r);
      bpa_rsp_type res;
      int unsigned k;
      int unsigned p;
      int unsigned b;
      int unsigned lim;
      res = '{status: STAT_DONE, block_page: '0};
      if (r.action == ACT_ALLOC) begin
         k = 32'(r.req_order);
         while (k < NORD && count[k] == 0) k++;
         if (r.req_order >= NORD || k >= NORD) begin
            res.status = STAT_NO_BLOCK;
         end else begin
            p = head[k] % NPAGE;
            unlink_free(p, k);
            while (k > r.req_order) begin
               k--;
               push_free(p, k);
               p += 1 << k;
            end
            pg_used[p] = 1'b1;
            pg_order[p] = {1'b0, r.req_order};
            res.block_page = p[11:0];
         end
      end else if (r.action == ACT_FREE) begin
         p = 32'(r.page_index);
         if (pg_used[p] && pg_order[p] < NORD) begin
            k = 32'(pg_order[p]);
            pg_used[p] = 1'b0;
            while (k + 1 < NORD) begin
               b = p ^ (1 << k);
               if (b >= NPAGE || pg_used[b] || pg_order[b] != k) break;
               unlink_free(b, k);
               pg_order[(b < p) ? p : b] = NO_ORDER;
               pg_used[(b < p) ? p : b] = 1'b0;
               p = (b < p) ? b : p;
               k++;
            end
            push_free(p, k);
         end
      end else if (r.action == ACT_INIT) begin
         lim = (cfg_end < NPAGE) ? 32'(cfg_end) : NPAGE;
         p = 32'(cfg_first_free);
         k = NORD - 1;
         wipe_pages();
         if (p % (1 << NORD) != 0) p += (1 << NORD) - p % (1 << NORD);
         while (p < lim) begin
            if (p + (1 << k) <= lim) begin
               push_free(p, k);
               for (int j = 1; j < (1 << k); j++) begin
                  pg_used[p + j] = 1'b0;
                  pg_order[p + j] = NO_ORDER;
               end
               p += 1 << k;
            end else if (k > 0) begin
               k--;
            end else begin
               break;
            end
         end
      end
      return res;
   endfunction

   // Sends one item, waits for its acceptance and records the expected response.
   // Valid is dropped only while the sender idles or drains, so an item that
   // follows straight away keeps valid high with its own payload.
   task automatic send_item(bpa_req_type r);
      bpa_rsp_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      res = predict_alloc(r);
      owed_rsp.push_back(res);
      if (r.action == ACT_INIT) held_pages.delete();
      if (r.action == ACT_ALLOC && res.status == STAT_DONE)
         held_pages.push_back(res.block_page);
   endtask

   task automatic send_op(logic [1:0] act, int unsigned ord, int unsigned pg);
      bpa_req_type r;
      r.action = act;
      r.req_order = ord[3:0];
      r.page_index = pg[11:0];
      send_item(r);
   endtask

   // Frees a page picked from the held set, removing it from that set.
   task automatic free_held();
      int unsigned i;
      int unsigned pg;
      i = $urandom_range(held_pages.size() - 1);
      pg = held_pages[i];
      held_pages.delete(i);
      send_op(ACT_FREE, 0, pg);
   endtask

   // Waits until every response has come, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      if (idx == CSR_FIRST_FREE) cfg_first_free = val[11:0];
      else cfg_end = val[12:0];
   endtask

   task automatic configure(int unsigned first_pg, int unsigned end_pg);
      drain();
      write_csr(CSR_FIRST_FREE, first_pg);
      write_csr(CSR_END_PAGE, end_pg);
      csr_we <= 1'b0;
   endtask

   // Directed corners: empty lists, oversized requests, every bad free, action 3.
   task automatic test_directed();
      send_op(ACT_ALLOC, 0, 0);
      send_op(ACT_FREE, 0, 12'hFFF);
      send_op(ACT_NONE, 4'hF, 12'hABC);
      configure(12'd1, 13'd3000);
      send_op(ACT_INIT, 0, 0);
      send_op(ACT_ALLOC, 4'hF, 0);
      send_op(ACT_ALLOC, NORD, 0);
      send_op(ACT_ALLOC, NORD - 1, 0);
      send_op(ACT_ALLOC, 0, 0);
      send_op(ACT_ALLOC, 3, 0);
      send_op(ACT_FREE, 0, 0);
      send_op(ACT_FREE, 0, 12'd1500);
      send_op(ACT_FREE, 0, 12'hFFF);
      while (held_pages.size() != 0) free_held();
      send_op(ACT_FREE, 0, 12'd2047);
      send_op(ACT_NONE, 0, 12'h555);
      configure(12'd0, 13'd4096);
      send_op(ACT_INIT, 0, 0);
      for (int i = 0; i < 3; i++) send_op(ACT_ALLOC, NORD - 1, 0);
      send_op(ACT_ALLOC, 0, 0);
      while (held_pages.size() != 0) free_held();
   endtask

   // Random traffic: mostly allocations and frees of held pages.
   task automatic test_random(int unsigned n_items);
      int unsigned sel;
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(99);
         if (sel < 45) begin
            send_op(ACT_ALLOC, ($urandom_range(3) == 0) ? $urandom_range(15)
                                                          : $urandom_range(3), 0);
         end else if (sel < 85 && held_pages.size() != 0) begin
            free_held();
         end else if (sel < 97) begin
            send_op(ACT_FREE, $urandom_range(15), $urandom_range(NPAGE - 1));
         end else begin
            send_op(ACT_NONE, $urandom_range(15), $urandom_range(NPAGE - 1));
         end
      end
   endtask

   // Reconfigures at the extremes and at random points, then runs traffic.
   task automatic test_configs();
      configure(12'd4095, 13'd8191);
      send_op(ACT_INIT, 0, 0);
      test_random(20);
      configure(12'd0, 13'd0);
      send_op(ACT_INIT, 0, 0);
      test_random(20);
      configure(12'd1024, 13'd1024 + 13'd777);
      send_op(ACT_INIT, 0, 0);
      test_random(60);
      configure($urandom_range(4095), $urandom_range(8191));
      send_op(ACT_INIT, 0, 0);
      test_random(60);
   endtask

   // Checks each accepted response against the oldest expectation.
   always @(posedge clock) begin
      bpa_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_rsp.size() == 0) begin
            $error("unexpected response status=%0d block_page=%0d",
                   rsp_data.status, rsp_data.block_page);
            fail_count++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.block_page !== want.block_page) begin
               $error("block_page: expected %0d, actual %0d",
                      want.block_page, rsp_data.block_page);
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("buddy_page_allocator_test: FAIL");
         $finish;
      end
   end

   initial begin
      cfg_first_free = '0;
      cfg_end = 13'd4096;
      wipe_pages();
      for (int i = 0; i < NORD; i++) begin
         head[i] = 0;
         tail[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 22;
      recv_stall_pct = 72;
      test_directed();
      test_configs();
      send_idle_pct = 72;
      recv_stall_pct = 22;
      configure(12'd700, 13'd4000);
      send_op(ACT_INIT, 0, 0);
      test_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      configure(12'd0, 13'd4096);
      send_op(ACT_INIT, 0, 0);
      test_random(300);
      drain();
      if (fail_count == 0 && owed_rsp.size() == 0) begin
         $display("buddy_page_allocator_test: PASS");
      end else begin
         $display("buddy_page_allocator_test: FAIL");
      end
      $finish;
   end

endmodule
